// File: rtl/core/scc_pkg.sv
// Shared constants for the strongly connected components block.
`timescale 1ns / 1ps
package scc_pkg;
   localparam int unsigned NodeIdWidth = 6;
   localparam int unsigned SizeWidth   = 7;
endpackage

// File: rtl/core/strongly_connected_components_top.sv
// Top level of the strongly connected components block (Kosaraju's method).
//
// Usage: edges are given one per transaction on req_src_node / req_dst_node.
// A transaction is accepted on a rising edge where start is high and busy
// is low. Edges can follow back to back while loading.
// The edge with req_last_edge set starts the search; busy stays high until
// every result is sent. Results come one per component in ascending leader
// id, each valid for exactly one cycle while rsp_valid is high; the receiver
// cannot stall. rsp_last_component marks the final result, rsp_edges_dropped
// reports that an edge arrived while edge storage was full.
// Search: each edge test reads the edge (ST_RDE), then compares it (ST_CHK),
// and each stack frame walks the edge list once in total, resuming from its
// saved position. Pass 1 sweeps the ids once, pass 2 reads each finished
// node (ST_P2RD), and the output sweep reads and then sends for each id
// (ST_OUTRD, ST_OUT), so results never come back to back. The edge scan
// sets the search time.
// Reset clears the edge count, presence bits, counts and the dropped flag;
// the edge memory holds no reset value.
`timescale 1ns / 1ps
module strongly_connected_components_top #(
   parameter int unsigned MAX_NODES = 64,
   parameter int unsigned MAX_EDGES = 1024
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic [scc_pkg::NodeIdWidth-1:0] req_src_node,
   input  logic [scc_pkg::NodeIdWidth-1:0] req_dst_node,
   input  logic req_last_edge,
   output logic rsp_valid,
   output logic [scc_pkg::NodeIdWidth-1:0] rsp_leader_node,
   output logic [scc_pkg::SizeWidth-1:0] rsp_component_size,
   output logic rsp_last_component,
   output logic rsp_edges_dropped
);
   import scc_pkg::*;

   localparam int unsigned NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int unsigned EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int unsigned ECW = $clog2(MAX_EDGES + 1);
   localparam int unsigned NCW = $clog2(MAX_NODES + 1);

   localparam logic [3:0] ST_LOAD  = 4'd0;
   localparam logic [3:0] ST_P1SEL = 4'd1;
   localparam logic [3:0] ST_PUSH  = 4'd2;
   localparam logic [3:0] ST_TOP   = 4'd3;
   localparam logic [3:0] ST_RDE   = 4'd4;
   localparam logic [3:0] ST_CHK   = 4'd5;
   localparam logic [3:0] ST_P2SEL = 4'd6;
   localparam logic [3:0] ST_P2RD  = 4'd7;
   localparam logic [3:0] ST_OUTRD = 4'd8;
   localparam logic [3:0] ST_OUT   = 4'd9;
   localparam logic [3:0] ST_CLR   = 4'd10;

   // Edge memories and per-node stores.
   logic [NodeIdWidth-1:0] esrc_mem [MAX_EDGES];
   logic [NodeIdWidth-1:0] edst_mem [MAX_EDGES];
   logic [NW-1:0]  fin_mem   [MAX_NODES];
   logic [NW-1:0]  stk_node  [MAX_NODES];
   logic [ECW-1:0] stk_pos   [MAX_NODES];
   logic [SizeWidth-1:0] cnt_mem [MAX_NODES];
   logic [MAX_NODES-1:0] present_ff, visited_ff, counted_ff;

   logic [3:0] state_ff;
   logic [ECW-1:0] ecount_ff;
   logic dropped_ff;
   logic pass2_ff;
   logic [NCW-1:0] scan_ff;     // pass 1 id sweep, pass 2 finish index, output sweep
   logic [NCW-1:0] finlen_ff;
   logic [NCW-1:0] sp_ff;
   logic [NW-1:0] leader_ff;
   logic [NW-1:0] cur_node_ff;
   logic [ECW-1:0] cur_pos_ff;
   logic [NW-1:0] push_node_ff;
   logic [NodeIdWidth-1:0] ea_ff, eb_ff;
   logic [NW-1:0] fin_rd_ff;
   logic [SizeWidth-1:0] cnt_rd_ff;
   logic [NCW-1:0] comps_ff, sent_ff;
   logic [SizeWidth-1:0] size_ff, size_in;

   logic [NodeIdWidth-1:0] from_n, to_n;
   logic accept, in_range;

   assign busy   = (state_ff != ST_LOAD);
   assign accept = start && !busy;
   assign in_range = (NodeIdWidth'(req_src_node) < MAX_NODES) &&
                     (NodeIdWidth'(req_dst_node) < MAX_NODES) ||
                     (MAX_NODES >= (1 << NodeIdWidth));
   assign from_n = pass2_ff ? ea_ff : eb_ff;
   assign to_n   = pass2_ff ? eb_ff : ea_ff;
   // The running member count of the current leader restarts at its first push.
   assign size_in = (sp_ff == '0) ? SizeWidth'(1) : size_ff + 1'b1;

   // Edge memory: write at load, registered read during the search.
   always_ff @(posedge clock) begin
      if (accept && in_range && ecount_ff < ECW'(MAX_EDGES)) begin
         esrc_mem[ecount_ff[EAW-1:0]] <= req_src_node;
         edst_mem[ecount_ff[EAW-1:0]] <= req_dst_node;
      end
      ea_ff <= esrc_mem[cur_pos_ff[EAW-1:0]];
      eb_ff <= edst_mem[cur_pos_ff[EAW-1:0]];
      fin_rd_ff <= fin_mem[NW'(scan_ff - 1'b1)];
      cnt_rd_ff <= cnt_mem[scan_ff[NW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         ecount_ff  <= '0;
         dropped_ff <= 1'b0;
         present_ff <= '0;
         visited_ff <= '0;
         counted_ff <= '0;
         rsp_valid  <= 1'b0;
         pass2_ff   <= 1'b0;
         scan_ff    <= '0;
         finlen_ff  <= '0;
         sp_ff      <= '0;
         comps_ff   <= '0;
         sent_ff    <= '0;
      end else begin
         rsp_valid <= 1'b0;
         case (state_ff)
            ST_LOAD: begin
               if (accept) begin
                  if (in_range) begin
                     if (ecount_ff < ECW'(MAX_EDGES)) begin
                        ecount_ff <= ecount_ff + 1'b1;
                        present_ff[req_src_node[NW-1:0]] <= 1'b1;
                        present_ff[req_dst_node[NW-1:0]] <= 1'b1;
                     end else begin
                        dropped_ff <= 1'b1;
                     end
                  end
                  if (req_last_edge) begin
                     state_ff  <= ST_P1SEL;
                     pass2_ff  <= 1'b0;
                     visited_ff <= '0;
                     scan_ff   <= NCW'(MAX_NODES);
                     finlen_ff <= '0;
                  end
               end
            end
            ST_P1SEL: begin
               // Sweep ids downward and start a reverse search at each fresh one.
               if (scan_ff == '0) begin
                  state_ff   <= ST_P2SEL;
                  pass2_ff   <= 1'b1;
                  visited_ff <= '0;
                  scan_ff    <= finlen_ff;
               end else begin
                  scan_ff <= scan_ff - 1'b1;
                  if (present_ff[NW'(scan_ff - 1'b1)] && !visited_ff[NW'(scan_ff - 1'b1)]) begin
                     push_node_ff <= NW'(scan_ff - 1'b1);
                     sp_ff        <= '0;
                     state_ff     <= ST_PUSH;
                  end
               end
            end
            ST_P2SEL: begin
               if (scan_ff == '0) begin
                  state_ff <= ST_OUTRD;
                  comps_ff <= NCW'($countones(counted_ff));
                  sent_ff  <= '0;
               end else begin
                  scan_ff  <= scan_ff - 1'b1;
                  state_ff <= ST_P2RD;
               end
            end
            ST_P2RD: begin
               // fin_rd_ff holds finish_order at the decremented index.
               state_ff <= ST_P2SEL;
               if (!visited_ff[fin_rd_ff]) begin
                  push_node_ff <= fin_rd_ff;
                  leader_ff    <= fin_rd_ff;
                  sp_ff        <= '0;
                  state_ff     <= ST_PUSH;
               end
            end
            ST_PUSH: begin
               visited_ff[push_node_ff] <= 1'b1;
               stk_node[sp_ff[NW-1:0]] <= push_node_ff;
               stk_pos[sp_ff[NW-1:0]]  <= '0;
               if (pass2_ff) begin
                  cnt_mem[leader_ff]    <= size_in;
                  size_ff               <= size_in;
                  counted_ff[leader_ff] <= 1'b1;
               end
               cur_node_ff <= push_node_ff;
               cur_pos_ff  <= '0;
               sp_ff    <= sp_ff + 1'b1;
               state_ff <= ST_RDE;
            end
            ST_TOP: begin
               cur_node_ff <= stk_node[NW'(sp_ff - 1'b1)];
               cur_pos_ff  <= stk_pos[NW'(sp_ff - 1'b1)];
               state_ff    <= ST_RDE;
            end
            ST_RDE: begin
               if (cur_pos_ff >= ecount_ff) begin
                  // Frame exhausted: pop and record finish.
                  sp_ff <= sp_ff - 1'b1;
                  if (!pass2_ff && finlen_ff < NCW'(MAX_NODES)) begin
                     fin_mem[finlen_ff[NW-1:0]] <= cur_node_ff;
                     finlen_ff <= finlen_ff + 1'b1;
                  end
                  if (sp_ff == NCW'(1)) state_ff <= pass2_ff ? ST_P2SEL : ST_P1SEL;
                  else state_ff <= ST_TOP;
               end else begin
                  state_ff <= ST_CHK;
               end
            end
            ST_CHK: begin
               cur_pos_ff <= cur_pos_ff + 1'b1;
               if (NW'(from_n) == cur_node_ff && !visited_ff[NW'(to_n)] &&
                   sp_ff < NCW'(MAX_NODES)) begin
                  stk_pos[NW'(sp_ff - 1'b1)] <= cur_pos_ff + 1'b1;
                  push_node_ff <= NW'(to_n);
                  state_ff     <= ST_PUSH;
               end else if (NW'(from_n) == cur_node_ff && !visited_ff[NW'(to_n)]) begin
                  // Stack full: the frame finishes as if its edges were used up.
                  stk_pos[NW'(sp_ff - 1'b1)] <= cur_pos_ff + 1'b1;
                  sp_ff <= sp_ff - 1'b1;
                  if (!pass2_ff && finlen_ff < NCW'(MAX_NODES)) begin
                     fin_mem[finlen_ff[NW-1:0]] <= cur_node_ff;
                     finlen_ff <= finlen_ff + 1'b1;
                  end
                  if (sp_ff == NCW'(1)) state_ff <= pass2_ff ? ST_P2SEL : ST_P1SEL;
                  else state_ff <= ST_TOP;
               end else begin
                  state_ff <= ST_RDE;
               end
            end
            ST_OUTRD: begin
               if (scan_ff == NCW'(MAX_NODES)) state_ff <= ST_CLR;
               else state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (counted_ff[scan_ff[NW-1:0]]) begin
                  rsp_valid          <= 1'b1;
                  rsp_leader_node    <= NodeIdWidth'(scan_ff);
                  rsp_component_size <= cnt_rd_ff;
                  rsp_last_component <= (sent_ff + 1'b1 == comps_ff);
                  rsp_edges_dropped  <= dropped_ff;
                  sent_ff <= sent_ff + 1'b1;
               end
               scan_ff  <= scan_ff + 1'b1;
               state_ff <= ST_OUTRD;
            end
            ST_CLR: begin
               ecount_ff  <= '0;
               dropped_ff <= 1'b0;
               present_ff <= '0;
               visited_ff <= '0;
               counted_ff <= '0;
               state_ff   <= ST_LOAD;
            end
            default: state_ff <= ST_LOAD;
         endcase
         if (state_ff == ST_P2SEL && scan_ff == '0) scan_ff <= '0;
      end
   end
endmodule
